// ===== rtl/core/nps_pkg.sv =====
// shared constants, codes and types of the nearest point search block
package nps_pkg;

  // table geometry
  localparam int MAX_POINTS = 1024;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = IDX_W + 1;

  // coordinate and distance widths
  localparam int COORD_W = 16;
  localparam int MAG_W   = COORD_W;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int DIST_W  = SQ_W + 1;

  // item function codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // result status codes
  localparam logic STATUS_FOUND = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } nps_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic write_en;
    logic issue;
  } nps_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic cnt_zero;
    logic last;
    logic pipe_busy;
  } nps_stat_t;

endpackage

// ===== rtl/core/nps_ctrl.sv =====
// controller state machine of the nearest point search block
module nps_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              func,
  input  nps_pkg::nps_stat_t stat,
  output nps_pkg::nps_cmd_t  cmd,
  output logic              busy,
  output logic              result_valid
);

  nps_pkg::nps_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nps_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next   = state;
    cmd          = '0;
    busy         = 1'b1;
    result_valid = 1'b0;
    unique case (state)
      nps_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (func == nps_pkg::FUNC_QUERY) begin
            cmd.load   = 1'b1;
            state_next = stat.cnt_zero ? nps_pkg::ST_DONE : nps_pkg::ST_SCAN;
          end else begin
            cmd.write_en = 1'b1;
          end
        end
      end
      nps_pkg::ST_SCAN: begin
        cmd.issue = 1'b1;
        if (stat.last) begin
          state_next = nps_pkg::ST_DRAIN;
        end
      end
      nps_pkg::ST_DRAIN: begin
        if (!stat.pipe_busy) begin
          state_next = nps_pkg::ST_DONE;
        end
      end
      nps_pkg::ST_DONE: begin
        result_valid = 1'b1;
        state_next   = nps_pkg::ST_IDLE;
      end
      default: begin
        state_next = nps_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/nps_datapath.sv =====
// point table, distance pipeline and running minimum
module nps_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  nps_pkg::nps_cmd_t                   cmd,
  output nps_pkg::nps_stat_t                  stat,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [nps_pkg::CNT_W-1:0]           cfg_data,
  input  logic [nps_pkg::IDX_W-1:0]           entry_index,
  input  logic signed [nps_pkg::COORD_W-1:0]  coord_x,
  input  logic signed [nps_pkg::COORD_W-1:0]  coord_y,
  output logic [nps_pkg::IDX_W-1:0]           nearest_index,
  output logic signed [nps_pkg::COORD_W-1:0]  nearest_x,
  output logic signed [nps_pkg::COORD_W-1:0]  nearest_y,
  output logic                                status
);

  localparam int CW = nps_pkg::COORD_W;
  localparam int IW = nps_pkg::IDX_W;

  // configuration register
  logic [nps_pkg::CNT_W-1:0] points_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      points_in_use <= '0;
    end else if (cfg_valid && cfg_ready) begin
      points_in_use <= cfg_data;
    end
  end

  // point table, x in the upper half
  logic [2*CW-1:0] mem [nps_pkg::MAX_POINTS];
  logic [2*CW-1:0] rd_data;

  // query state
  logic signed [CW-1:0] qx, qy;
  logic [IW-1:0]        limit;
  logic [IW-1:0]        rd_addr;
  logic                 empty_q;
  logic [IW-1:0]        limit_next;

  // last entry searched, count clamped to the table size
  always_comb begin
    if (points_in_use >= nps_pkg::CNT_W'(nps_pkg::MAX_POINTS)) begin
      limit_next = '1;
    end else begin
      limit_next = IW'(points_in_use - nps_pkg::CNT_W'(1));
    end
  end

  // table write and registered read
  always_ff @(posedge clk) begin
    if (cmd.write_en) begin
      mem[entry_index] <= {coord_x, coord_y};
    end
    if (cmd.issue) begin
      rd_data <= mem[rd_addr];
    end
  end

  // pipeline valid bits
  logic v_rd, v_d, v_s, v_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_rd <= 1'b0;
      v_d  <= 1'b0;
      v_s  <= 1'b0;
      v_t  <= 1'b0;
    end else begin
      v_rd <= cmd.issue;
      v_d  <= v_rd;
      v_s  <= v_d;
      v_t  <= v_s;
    end
  end

  // pipeline payload
  logic [IW-1:0]             idx_rd, idx_d, idx_s, idx_t;
  logic signed [CW-1:0]      px_d, py_d, px_s, py_s, px_t, py_t;
  logic [nps_pkg::MAG_W-1:0] dx, dy;
  logic [nps_pkg::SQ_W-1:0]  sx, sy;
  logic [nps_pkg::DIST_W-1:0] sum_sq;

  logic signed [CW-1:0] px_rd, py_rd;
  logic signed [CW:0]   diff_x, diff_y;
  logic [nps_pkg::MAG_W-1:0] mag_x, mag_y;

  // absolute coordinate differences
  always_comb begin
    px_rd  = rd_data[2*CW-1:CW];
    py_rd  = rd_data[CW-1:0];
    diff_x = {px_rd[CW-1], px_rd} - {qx[CW-1], qx};
    diff_y = {py_rd[CW-1], py_rd} - {qy[CW-1], qy};
    mag_x  = diff_x[CW] ? nps_pkg::MAG_W'(-diff_x) : nps_pkg::MAG_W'(diff_x);
    mag_y  = diff_y[CW] ? nps_pkg::MAG_W'(-diff_y) : nps_pkg::MAG_W'(diff_y);
  end

  // query load and address counter
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      qx      <= coord_x;
      qy      <= coord_y;
      limit   <= limit_next;
      rd_addr <= '0;
      empty_q <= (points_in_use == '0);
    end else if (cmd.issue) begin
      rd_addr <= rd_addr + IW'(1);
    end
    if (cmd.issue) begin
      idx_rd <= rd_addr;
    end
  end

  // difference, square and sum stages
  always_ff @(posedge clk) begin
    idx_d <= idx_rd;
    px_d  <= px_rd;
    py_d  <= py_rd;
    dx    <= mag_x;
    dy    <= mag_y;

    idx_s <= idx_d;
    px_s  <= px_d;
    py_s  <= py_d;
    sx    <= dx * dx;
    sy    <= dy * dy;

    idx_t  <= idx_s;
    px_t   <= px_s;
    py_t   <= py_s;
    sum_sq <= {1'b0, sx} + {1'b0, sy};
  end

  // running minimum, earlier entry kept on ties
  logic                       best_valid;
  logic [nps_pkg::DIST_W-1:0] best_dist;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      best_valid    <= 1'b0;
      nearest_index <= '0;
      nearest_x     <= '0;
      nearest_y     <= '0;
    end else if (v_t && (!best_valid || sum_sq < best_dist)) begin
      best_valid    <= 1'b1;
      best_dist     <= sum_sq;
      nearest_index <= idx_t;
      nearest_x     <= px_t;
      nearest_y     <= py_t;
    end
  end

  assign status = empty_q ? nps_pkg::STATUS_EMPTY : nps_pkg::STATUS_FOUND;

  // status to the controller
  always_comb begin
    stat.cnt_zero  = (points_in_use == '0);
    stat.last      = (rd_addr == limit);
    stat.pipe_busy = v_rd | v_d | v_s | v_t;
  end

endmodule

// ===== rtl/core/nearest_point_search.sv =====
// nearest point search top level: controller and datapath
// write item: taken with busy low and leaves busy low, so writes may follow every cycle
// query item: busy until after the result strobe, which ends a scan of N entries,
//   N = points_in_use clamped to the table size, with one table read per cycle
//   over a five-stage distance pipeline; an empty table strobes in the next cycle
// one-cycle strobe, no stall; sync reset clears control and points_in_use, not the table
module nearest_point_search (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                func,
  input  logic [nps_pkg::IDX_W-1:0]           entry_index,
  input  logic signed [nps_pkg::COORD_W-1:0]  coord_x,
  input  logic signed [nps_pkg::COORD_W-1:0]  coord_y,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [nps_pkg::CNT_W-1:0]           cfg_data,
  output logic                                result_valid,
  output logic [nps_pkg::IDX_W-1:0]           nearest_index,
  output logic signed [nps_pkg::COORD_W-1:0]  nearest_x,
  output logic signed [nps_pkg::COORD_W-1:0]  nearest_y,
  output logic                                status
);

  nps_pkg::nps_cmd_t  cmd;
  nps_pkg::nps_stat_t stat;

  // configuration is taken while no item is in flight
  assign cfg_ready = !busy;

  // sequencing
  nps_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .func         (func),
    .stat         (stat),
    .cmd          (cmd),
    .busy         (busy),
    .result_valid (result_valid)
  );

  // table and search datapath
  nps_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .entry_index   (entry_index),
    .coord_x       (coord_x),
    .coord_y       (coord_y),
    .nearest_index (nearest_index),
    .nearest_x     (nearest_x),
    .nearest_y     (nearest_y),
    .status        (status)
  );

endmodule

// ===== rtl/core/nps_checker.sv =====
// port-level checks of the nearest point search block, bound to the top level
module nps_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                start,
  input logic                                busy,
  input logic                                func,
  input logic                                result_valid,
  input logic [nps_pkg::IDX_W-1:0]           nearest_index,
  input logic signed [nps_pkg::COORD_W-1:0]  nearest_x,
  input logic signed [nps_pkg::COORD_W-1:0]  nearest_y,
  input logic                                status
);

  // a query item makes the block busy
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && func == nps_pkg::FUNC_QUERY |=> busy)
    else $error("query item did not raise busy");

  // a write item leaves the block free
  a_write_free: assert property (@(posedge clk) disable iff (rst)
    start && !busy && func == nps_pkg::FUNC_WRITE |=> !busy)
    else $error("write item raised busy");

  // the strobe lasts one cycle and frees the block
  a_strobe_single: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid && !busy)
    else $error("result strobe held or block stayed busy");

  // an empty-table answer carries zero fields
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && status == nps_pkg::STATUS_EMPTY |->
      nearest_index == '0 && nearest_x == '0 && nearest_y == '0)
    else $error("empty-table result with nonzero fields");

  // a result only comes while a query is in flight
  a_result_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> busy)
    else $error("result strobe while idle");

endmodule

bind nearest_point_search nps_checker u_nps_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .func          (func),
  .result_valid  (result_valid),
  .nearest_index (nearest_index),
  .nearest_x     (nearest_x),
  .nearest_y     (nearest_y),
  .status        (status)
);
